// ----- design/svpwm_min_max_duty_generator_macros.svh -----
// assertion macros shared by the svpwm min-max duty generator rtl
// no dependencies; included by modules that carry assertions
`ifndef SVPWM_MIN_MAX_DUTY_GENERATOR_MACROS_SVH
`define SVPWM_MIN_MAX_DUTY_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SVMM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svmm assertion failed");
// next-cycle implication, checked out of reset
`define SVMM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svmm assertion failed");
`else
`define SVMM_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SVMM_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/svmm_pkg.sv -----
// types and constants for the svpwm min-max duty generator
// no dependencies; imported by every module of the block
`default_nettype none

package svmm_pkg;

    // field widths
    localparam int IN_W   = 16;
    localparam int DUTY_W = 16;
    localparam int LIM_W  = 15;

    // internal datapath widths
    localparam int BK_W   = 34;  // beta times sqrt3 in q16
    localparam int PH_W   = 35;  // doubled phase voltage in q16
    localparam int M_W    = 37;  // injected numerator, signed
    localparam int N_W    = 38;  // numerator magnitude and overflow limit
    localparam int REM_W  = 34;  // divider remainder
    localparam int QUO_W  = 15;  // quotient bits kept before saturation
    localparam int DEN_W  = 19;  // eight times bus voltage
    localparam int D_W    = 17;  // signed duty before clamp

    // constants
    localparam logic signed [17:0]   SQRT3_Q16  = 18'sd113512;
    localparam logic [IN_W-1:0]      BUS_MIN    = 16'd25;
    localparam logic [LIM_W-1:0]     DUTY_HALF  = 15'd16384;
    localparam logic [DUTY_W:0]      DUTY_FULL  = 17'd32768;

    // one phase lane inside the divider chain
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } t_lane;

    // request payload carried from cell to cell
    typedef struct packed {
        t_lane [2:0]      lane;
        logic [DEN_W-1:0] den;
        logic             low;
    } t_div_pl;

endpackage

`default_nettype wire

// ----- design/svpwm_min_max_duty_generator.sv -----
// path: an accepted request passes through 22 registers before it reaches the output
// (6 front stages, 15 divider cells, 1 output; the first loads at acceptance)
// throughput: one request per cycle; under back-pressure only empty stages keep filling
// reset: i_rst_n low at a clock edge empties the pipeline and clears the lower clamp to 0
// depends on svmm_pkg, svmm_front, svmm_div_cell, svmm_duty
`default_nettype none

module svpwm_min_max_duty_generator
    import svmm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration: lower duty clamp, q0.15
    input  wire logic             i_cfg_we,
    input  wire logic [LIM_W-1:0] i_cfg_wdata,
    // request side
    input  wire logic             i_s_axis_tvalid,
    output      logic             o_s_axis_tready,
    // tdata: alpha_volts [15:0], beta_volts [31:16], bus_volts [47:32]
    input  wire logic [47:0]      i_s_axis_tdata,
    // result side
    output      logic             o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    // tdata: duty_phase_a [15:0], duty_phase_b [31:16], duty_phase_c [47:32]
    output      logic [47:0]      o_m_axis_tdata,
    // tuser: limit_hit [0]
    output      logic             o_m_axis_tuser
);

    logic signed [IN_W-1:0] w_alpha, w_beta;
    logic [IN_W-1:0]        w_bus;
    t_div_pl                w_pl  [QUO_W+1];
    logic                   w_v   [QUO_W+1];
    logic                   w_rdy [QUO_W+1];
    logic [2:0][DUTY_W-1:0] w_duty;

    // unpack request fields
    assign w_alpha = $signed(i_s_axis_tdata[15:0]);
    assign w_beta  = $signed(i_s_axis_tdata[31:16]);
    assign w_bus   = i_s_axis_tdata[47:32];

    // phase voltages and divider setup
    svmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_alpha (w_alpha),
        .i_beta  (w_beta),
        .i_bus   (w_bus),
        .o_valid (w_v[0]),
        .i_ready (w_rdy[0]),
        .o_pl    (w_pl[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        svmm_div_cell #(
            .BIT_IDX (QUO_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_pl    (w_pl[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_pl    (w_pl[g+1])
        );
    end

    // clamp, flag and output register
    svmm_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_v[QUO_W]),
        .o_ready     (w_rdy[QUO_W]),
        .i_pl        (w_pl[QUO_W]),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_duty      (w_duty),
        .o_hit       (o_m_axis_tuser)
    );

    // pack result fields
    assign o_m_axis_tdata = {w_duty[2], w_duty[1], w_duty[0]};

endmodule

`default_nettype wire

// ----- design/svmm_front.sv -----
// front pipeline: inverse clarke, min-max injection, divider setup
// depends on svmm_pkg
`default_nettype none

module svmm_front
    import svmm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output      logic                   o_ready,
    input  wire logic signed [IN_W-1:0] i_alpha,
    input  wire logic signed [IN_W-1:0] i_beta,
    input  wire logic [IN_W-1:0]        i_bus,
    output      logic                   o_valid,
    input  wire logic                   i_ready,
    output      t_div_pl                o_pl
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    // stage 1: products
    logic signed [PH_W-1:0] r1_na, r1_a16, n1_na, n1_a16;
    logic signed [BK_W-1:0] r1_bk, n1_bk;
    logic [IN_W-1:0]        r1_bus;
    logic [N_W-1:0]         r1_lim, n1_lim;
    // stage 2: phases
    logic signed [PH_W-1:0] r2_ph [3];
    logic signed [PH_W-1:0] n2_nb, n2_nc;
    logic [IN_W-1:0]        r2_bus;
    logic [N_W-1:0]         r2_lim;
    // stage 3: max and min
    logic signed [PH_W-1:0] r3_ph [3];
    logic signed [PH_W-1:0] r3_mx, r3_mn, n3_mx, n3_mn;
    logic [IN_W-1:0]        r3_bus;
    logic [N_W-1:0]         r3_lim;
    // stage 4: injected numerators
    logic signed [M_W-1:0]  r4_m [3];
    logic signed [M_W-1:0]  n4_m [3];
    logic [IN_W-1:0]        r4_bus;
    logic [N_W-1:0]         r4_lim;
    // stage 5: magnitudes
    logic [N_W-1:0]         r5_mag [3];
    logic [N_W-1:0]         n5_mag [3];
    logic [2:0]             r5_neg;
    logic [IN_W-1:0]        r5_bus;
    logic [N_W-1:0]         r5_lim;
    // stage 6: divider request
    t_div_pl                r6_pl, n6_pl;

    // stall chain, a stage moves when empty or when its successor moves
    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_pl    = r6_pl;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1 next values: scaled alpha, beta times sqrt3, overflow limit
    always_comb begin
        n1_na  = PH_W'(i_alpha) <<< 17;
        n1_a16 = PH_W'(i_alpha) <<< 16;
        n1_bk  = i_beta * SQRT3_Q16;
        // quotient reaches 2^15 once mag >= 8*bus*2^15 - 4*bus
        n1_lim = (N_W'(i_bus) << 18) - (N_W'(i_bus) << 2);
    end

    // stage 2 next values: phases b and c
    always_comb begin
        n2_nb = -r1_a16 + PH_W'(r1_bk);
        n2_nc = -r1_a16 - PH_W'(r1_bk);
    end

    // stage 3 next values: max and min of the three phases
    always_comb begin
        n3_mx = r2_ph[0];
        n3_mn = r2_ph[0];
        for (int k = 1; k < 3; k++) begin
            if (r2_ph[k] > n3_mx) begin
                n3_mx = r2_ph[k];
            end
            if (r2_ph[k] < n3_mn) begin
                n3_mn = r2_ph[k];
            end
        end
    end

    // stage 4 and 5 next values: common-mode injection, then magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_m[k]   = (M_W'(r3_ph[k]) <<< 1) - M_W'(r3_mx) - M_W'(r3_mn);
            n5_mag[k] = r4_m[k][M_W-1] ? N_W'(-r4_m[k]) : N_W'(r4_m[k]);
        end
    end

    // stage 6 next values: rounding bias, saturation preset, divisor
    always_comb begin
        logic [N_W-1:0] num;
        logic           ovf;
        n6_pl = '0;
        for (int k = 0; k < 3; k++) begin
            num = r5_mag[k] + (N_W'(r5_bus) << 2);
            ovf = r5_mag[k] >= r5_lim;
            n6_pl.lane[k].neg = r5_neg[k];
            n6_pl.lane[k].rem = ovf ? '0 : num[REM_W-1:0];
            n6_pl.lane[k].quo = ovf ? '1 : '0;
        end
        n6_pl.den = DEN_W'(r5_bus) << 3;
        n6_pl.low = r5_bus <= BUS_MIN;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_na  <= n1_na;
            r1_a16 <= n1_a16;
            r1_bk  <= n1_bk;
            r1_bus <= i_bus;
            r1_lim <= n1_lim;
        end
        if (w_en[1]) begin
            r2_ph[0] <= r1_na;
            r2_ph[1] <= n2_nb;
            r2_ph[2] <= n2_nc;
            r2_bus   <= r1_bus;
            r2_lim   <= r1_lim;
        end
        if (w_en[2]) begin
            r3_ph  <= r2_ph;
            r3_mx  <= n3_mx;
            r3_mn  <= n3_mn;
            r3_bus <= r2_bus;
            r3_lim <= r2_lim;
        end
        if (w_en[3]) begin
            r4_m   <= n4_m;
            r4_bus <= r3_bus;
            r4_lim <= r3_lim;
        end
        if (w_en[4]) begin
            r5_mag <= n5_mag;
            for (int k = 0; k < 3; k++) begin
                r5_neg[k] <= r4_m[k][M_W-1];
            end
            r5_bus <= r4_bus;
            r5_lim <= r4_lim;
        end
        if (w_en[5]) begin
            r6_pl <= n6_pl;
        end
    end

endmodule

`default_nettype wire

// ----- design/svmm_div_cell.sv -----
// one divider cell: resolves a single quotient bit for all three phases
// depends on svmm_pkg and the shared assertion macros
`default_nettype none
`include "svpwm_min_max_duty_generator_macros.svh"

module svmm_div_cell
    import svmm_pkg::*;
#(
    parameter int unsigned BIT_IDX = 0
)
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output      logic    o_ready,
    input  wire t_div_pl i_pl,
    output      logic    o_valid,
    input  wire logic    i_ready,
    output      t_div_pl o_pl
);

    logic             r_valid;
    t_div_pl          r_pl, n_pl;
    logic [REM_W-1:0] w_dsh_in, w_dsh_out;

    assign o_ready   = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_pl      = r_pl;
    assign w_dsh_in  = REM_W'(i_pl.den) << BIT_IDX;
    assign w_dsh_out = REM_W'(r_pl.den) << BIT_IDX;

    // trial subtract of the shifted divisor in each lane
    always_comb begin
        logic [REM_W:0] diff;
        n_pl = i_pl;
        for (int k = 0; k < 3; k++) begin
            diff = {1'b0, i_pl.lane[k].rem} - {1'b0, w_dsh_in};
            if (!diff[REM_W]) begin
                n_pl.lane[k].rem          = diff[REM_W-1:0];
                n_pl.lane[k].quo[BIT_IDX] = 1'b1;
            end
        end
    end

    // cell valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pl <= n_pl;
        end
    end

    // restoring invariant: remainder stays below the divisor at this weight
    `SVMM_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, r_valid && !r_pl.low,
        (r_pl.lane[0].rem < w_dsh_out) && (r_pl.lane[1].rem < w_dsh_out)
        && (r_pl.lane[2].rem < w_dsh_out))

endmodule

`default_nettype wire

// ----- design/svmm_duty.sv -----
// duty stage: signed offset, clamp to the duty window, limit flag, output register
// depends on svmm_pkg and the shared assertion macros
`default_nettype none
`include "svpwm_min_max_duty_generator_macros.svh"

module svmm_duty
    import svmm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [LIM_W-1:0]        i_cfg_wdata,
    input  wire logic                    i_valid,
    output      logic                    o_ready,
    input  wire t_div_pl                 i_pl,
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      logic [2:0][DUTY_W-1:0]  o_duty,
    output      logic                    o_hit
);

    logic [LIM_W-1:0]       r_lim;
    logic [LIM_W-1:0]       w_lo;
    logic [DUTY_W-1:0]      w_hi;
    logic                   r_valid;
    logic [2:0][DUTY_W-1:0] r_duty, n_duty;
    logic                   r_hit, n_hit;

    // lower clamp register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= '0;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    // clamp window, lower limit saturates at one half
    assign w_lo = (r_lim > DUTY_HALF) ? DUTY_HALF : r_lim;
    assign w_hi = DUTY_W'(DUTY_FULL - {2'b0, w_lo});

    // duty per phase and limit flag
    always_comb begin
        logic signed [D_W-1:0] d;
        logic signed [D_W-1:0] lo_s;
        logic signed [D_W-1:0] hi_s;
        logic signed [D_W-1:0] q_s;
        logic signed [D_W-1:0] half_s;
        lo_s   = $signed({2'b0, w_lo});
        hi_s   = $signed({1'b0, w_hi});
        half_s = $signed({2'b0, DUTY_HALF});
        n_hit  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            q_s = $signed({2'b0, i_pl.lane[k].quo});
            d   = i_pl.lane[k].neg ? (half_s - q_s) : (half_s + q_s);
            if (d < lo_s) begin
                d = lo_s;
            end else if (d > hi_s) begin
                d = hi_s;
            end
            if ((d <= lo_s) || (d >= hi_s)) begin
                n_hit = 1'b1;
            end
            n_duty[k] = d[DUTY_W-1:0];
        end
        // low bus voltage forces one half everywhere
        if (i_pl.low) begin
            for (int k = 0; k < 3; k++) begin
                n_duty[k] = {1'b0, DUTY_HALF};
            end
            n_hit = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_duty  = r_duty;
    assign o_hit   = r_hit;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_duty <= n_duty;
            r_hit  <= n_hit;
        end
    end

    // every delivered duty lies inside the clamp window
    `SVMM_ASSERT_IMPL(a_duty_in_window, i_clk, i_rst_n, r_valid,
        (r_duty[0] >= {1'b0, w_lo}) && (r_duty[0] <= w_hi)
        && (r_duty[1] >= {1'b0, w_lo}) && (r_duty[1] <= w_hi)
        && (r_duty[2] >= {1'b0, w_lo}) && (r_duty[2] <= w_hi))

    // a duty sitting on a limit always raises the flag
    `SVMM_ASSERT_IMPL(a_limit_flags_hit, i_clk, i_rst_n,
        r_valid && ((r_duty[0] == {1'b0, w_lo}) || (r_duty[0] == w_hi)
        || (r_duty[1] == {1'b0, w_lo}) || (r_duty[1] == w_hi)
        || (r_duty[2] == {1'b0, w_lo}) || (r_duty[2] == w_hi)),
        r_hit)

    // a request taken from the last cell shows up in the output register
    `SVMM_ASSERT_NEXT(a_take_fills_output, i_clk, i_rst_n, i_valid && o_ready, r_valid)

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking bench for the svpwm min-max duty generator, random and directed vectors
// predicts each duty set in a small class and checks every response in order
// depends on svmm_pkg and svpwm_min_max_duty_generator
`default_nettype none

module tb_top
    import svmm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // fixed-point constants of the duty math, then back-pressure and drain settings
    localparam longint ROOT3_Q16   = 113512;
    localparam longint BUS_FLOOR   = 25;
    localparam longint HALF_DUTY   = 16384;
    localparam longint FULL_DUTY   = 32768;
    localparam int     HOLD_AFTER  = 560;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_WAIT  = 30;

    typedef struct packed {
        logic [IN_W-1:0]        bus;
        logic signed [IN_W-1:0] beta;
        logic signed [IN_W-1:0] alpha;
    } t_request;

    typedef struct packed {
        logic                hit;
        logic [DUTY_W-1:0]   c;
        logic [DUTY_W-1:0]   b;
        logic [DUTY_W-1:0]   a;
    } t_duty_set;

    // duty predictor and queue of duty sets still owed by the block
    class duty_board;
        longint    clamp_floor;
        int        errors;
        t_duty_set expected_duties[$];

        function new();
            clamp_floor = 0;
            errors      = 0;
        endfunction

        function void set_clamp_floor(logic [LIM_W-1:0] v);
            clamp_floor = longint'(v);
        endfunction

        function int pending();
            return expected_duties.size();
        endfunction

        // rounded division (ties away from zero), offset and clamp of one phase
        function logic [DUTY_W-1:0] phase_duty(longint num, longint den, longint lo,
                                               longint hi, inout bit hit);
            longint mag;
            longint q;
            longint d;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            d   = HALF_DUTY + ((num < 0) ? -q : q);
            if (d < lo) d = lo;
            if (d > hi) d = hi;
            if (d <= lo || d >= hi) hit = 1'b1;
            return d[DUTY_W-1:0];
        endfunction

        function void note_request(t_request r);
            t_duty_set exp_set;
            longint va, vb, den, lo, hi, pa, pb, pc, vmax, vmin;
            bit hit;
            hit = 1'b0;
            lo  = (clamp_floor > HALF_DUTY) ? HALF_DUTY : clamp_floor;
            hi  = FULL_DUTY - lo;
            if (longint'(r.bus) <= BUS_FLOOR) begin
                exp_set.a   = HALF_DUTY[DUTY_W-1:0];
                exp_set.b   = HALF_DUTY[DUTY_W-1:0];
                exp_set.c   = HALF_DUTY[DUTY_W-1:0];
                exp_set.hit = 1'b1;
            end else begin
                va   = longint'(r.alpha);
                vb   = longint'(r.beta);
                den  = 8 * longint'(r.bus);
                // doubled inverse clarke in q16
                pa   = va * 131072;
                pb   = -va * 65536 + vb * ROOT3_Q16;
                pc   = -va * 65536 - vb * ROOT3_Q16;
                vmax = pa;
                if (pb > vmax) vmax = pb;
                if (pc > vmax) vmax = pc;
                vmin = pa;
                if (pb < vmin) vmin = pb;
                if (pc < vmin) vmin = pc;
                exp_set.a   = phase_duty(2 * pa - vmax - vmin, den, lo, hi, hit);
                exp_set.b   = phase_duty(2 * pb - vmax - vmin, den, lo, hi, hit);
                exp_set.c   = phase_duty(2 * pc - vmax - vmin, den, lo, hi, hit);
                exp_set.hit = hit;
            end
            expected_duties.push_back(exp_set);
        endfunction

        function void check_duties(t_duty_set got);
            t_duty_set exp_set;
            if (expected_duties.size() == 0) begin
                errors++;
                $display("%0t: unexpected duty set a=%0d b=%0d c=%0d hit=%0d",
                         $time, got.a, got.b, got.c, got.hit);
                return;
            end
            exp_set = expected_duties.pop_front();
            if (got.a !== exp_set.a) begin
                errors++;
                $display("%0t: duty_phase_a expected %0d actual %0d", $time, exp_set.a, got.a);
            end
            if (got.b !== exp_set.b) begin
                errors++;
                $display("%0t: duty_phase_b expected %0d actual %0d", $time, exp_set.b, got.b);
            end
            if (got.c !== exp_set.c) begin
                errors++;
                $display("%0t: duty_phase_c expected %0d actual %0d", $time, exp_set.c, got.c);
            end
            if (got.hit !== exp_set.hit) begin
                errors++;
                $display("%0t: limit_hit expected %0d actual %0d", $time, exp_set.hit, got.hit);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LIM_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [47:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [47:0]      m_tdata;
    logic             m_tuser;

    duty_board board;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_count;
    int        hold_left;

    always #5 i_clk = ~i_clk;

    svpwm_min_max_duty_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // response side: check accepted duty sets, random back-pressure, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            recv_count <= 0;
            hold_left  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                board.check_duties({m_tuser, m_tdata[47:32], m_tdata[31:16], m_tdata[15:0]});
                recv_count <= recv_count + 1;
            end
            if (m_tvalid && m_tready && recv_count == HOLD_AFTER) begin
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready  <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one request, with random idle cycles in front of it
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do @(posedge i_clk); while (!s_tready);
        board.note_request(r);
    endtask

    // stop offering and let every owed duty set come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_clamp_floor(input logic [LIM_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        board.set_clamp_floor(v);
    endtask

    task automatic send_vector(input int a, input int b, input int bus);
        t_request r;
        r.alpha = a[IN_W-1:0];
        r.beta  = b[IN_W-1:0];
        r.bus   = bus[IN_W-1:0];
        send_request(r);
    endtask

    // random vector, bus mostly scaled to the vector so duties land in range
    function automatic t_request random_request();
        t_request r;
        int mag;
        int sel;
        sel = $urandom_range(3);
        if (sel == 0) begin
            r.alpha = IN_W'($urandom_range(4000) - 2000);
            r.beta  = IN_W'($urandom_range(4000) - 2000);
        end else begin
            r.alpha = IN_W'($urandom);
            r.beta  = IN_W'($urandom);
        end
        mag = (r.alpha < 0 ? -int'(r.alpha) : int'(r.alpha))
            + (r.beta < 0 ? -int'(r.beta) : int'(r.beta));
        sel = $urandom_range(9);
        if (sel == 0) begin
            r.bus = IN_W'($urandom_range(30));
        end else if (sel < 3) begin
            r.bus = IN_W'($urandom);
        end else begin
            mag = 26 + mag + $urandom_range(mag);
            r.bus = (mag > 65535) ? 16'hFFFF : mag[IN_W-1:0];
        end
        return r;
    endfunction

    // main sequence
    initial begin
        logic [LIM_W-1:0] limit_set[6];
        board         = new();
        send_idle_pct = 24;
        recv_idle_pct = 50;
        i_rst_n   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed vectors at the reset clamp
        send_vector(0, 0, 1000);
        send_vector(32767, 0, 65535);
        send_vector(-32768, 0, 65535);
        send_vector(0, 32767, 65535);
        send_vector(0, -32768, 65535);
        send_vector(32767, 32767, 26);
        send_vector(-32768, -32768, 26);
        send_vector(1000, 0, 25);        // bus at the low-voltage threshold
        send_vector(1000, -1000, 0);     // no bus voltage at all
        send_vector(-32768, 32767, 1);
        send_vector(100, 50, 26);        // just above the threshold
        send_vector(1, 0, 26);
        send_vector(0, 1, 65535);
        send_vector(-1, -1, 65535);
        send_vector(256, 0, 256);
        send_vector(16384, 9459, 20000);
        send_vector(32767, -32768, 65535);
        send_vector(1, 0, 49152);        // rounding ties, positive on phase a
        send_vector(-1, 0, 49152);       // rounding ties, negative on phase a
        send_vector(0, 0, 65535);
        send_vector(12000, -7000, 14000);

        // random phases over lower clamp settings, including above-range
        limit_set[0] = LIM_W'($urandom_range(8000, 1));
        limit_set[1] = 15'd0;
        limit_set[2] = 15'd16384;
        limit_set[3] = 15'h7FFF;
        limit_set[4] = LIM_W'($urandom_range(16383, 1));
        limit_set[5] = 15'd1;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_clamp_floor(limit_set[ph]);
            send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 50 : 0;
            recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 24 : 0;
            for (int n = 0; n < 125; n++) send_request(random_request());
        end
        drain();

        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
